@@ rtl/core/abs_pkg.sv @@
// abs_pkg: shared types, command codes and checksum helpers for the
// alternating-bit sender. No dependencies; used by every module in rtl/core.
package abs_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_BITS  = 8 * PAYLOAD_BYTES;
    localparam int BSUM_WIDTH    = 13;
    localparam int TIMEOUT_WIDTH = 16;

    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd20;

    localparam logic [1:0] CMD_NEW   = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef logic [PAYLOAD_BITS-1:0] payload_t;

    typedef enum logic [1:0] {
        EV_NEW   = 2'd0,
        EV_REPLY = 2'd1,
        EV_TICK  = 2'd2
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t kind;
        logic     ack_bit;
        payload_t payload;
    } event_t;

    // sum of the 20 payload bytes, each sign-extended
    function automatic logic signed [BSUM_WIDTH-1:0] byte_sum(input payload_t p);
        logic signed [BSUM_WIDTH-1:0] acc;
        acc = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            acc = acc + BSUM_WIDTH'(signed'(p[8*i +: 8]));
        end
        return acc;
    endfunction

    function automatic logic [31:0] checksum(input logic [31:0] seq,
                                             input logic [31:0] ack,
                                             input payload_t    p);
        logic [31:0] s;
        s = seq + ack + 32'(byte_sum(p));
        return ~s;
    endfunction

endpackage

@@ rtl/core/abs_front.sv @@
// abs_front: accepts input words, verifies reply checksums and classifies
// them into events for the event queue. Depends on abs_pkg.
module abs_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [63:0]           s_payload_word0,
    input  logic [63:0]           s_payload_word1,
    input  logic [31:0]           s_payload_word2,
    input  logic signed [31:0]    s_reply_seq,
    input  logic signed [31:0]    s_reply_ack,
    input  logic [31:0]           s_reply_checksum,
    input  logic                  ev_in_ready,
    output logic                  ev_push,
    output abs_pkg::event_t       ev_data
);

    abs_pkg::payload_t payload;
    logic              reply_ok;
    logic              keep;

    assign payload = {s_payload_word2, s_payload_word1, s_payload_word0};

    // ack must be exactly 0 or 1 over all 32 bits
    assign reply_ok = (s_reply_checksum ==
                       abs_pkg::checksum(s_reply_seq, s_reply_ack, payload)) &&
                      (s_reply_ack[31:1] == 31'd0);

    always_comb begin
        keep            = 1'b0;
        ev_data.kind    = abs_pkg::EV_NEW;
        ev_data.ack_bit = s_reply_ack[0];
        ev_data.payload = payload;
        case (s_command)
            abs_pkg::CMD_NEW: begin
                keep         = 1'b1;
                ev_data.kind = abs_pkg::EV_NEW;
            end
            abs_pkg::CMD_REPLY: begin
                keep         = reply_ok;
                ev_data.kind = abs_pkg::EV_REPLY;
            end
            abs_pkg::CMD_TICK: begin
                keep         = 1'b1;
                ev_data.kind = abs_pkg::EV_TICK;
            end
            default: begin
                keep         = 1'b0;
                ev_data.kind = abs_pkg::EV_NEW;
            end
        endcase
    end

    assign s_ready = ev_in_ready;
    assign ev_push = s_valid && ev_in_ready && keep;

endmodule

@@ rtl/core/abs_fifo.sv @@
// abs_fifo: two-entry event queue between front and back.
// Depends on abs_pkg for the event type.
module abs_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  abs_pkg::event_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output abs_pkg::event_t out_data
);

    abs_pkg::event_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/core/abs_back.sv @@
// abs_back: protocol engine - message queue memory, header bits, retransmit
// timer and the result register. Depends on abs_pkg.
module abs_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [abs_pkg::TIMEOUT_WIDTH-1:0]   timeout_ticks,
    input  logic                                ev_valid,
    output logic                                ev_ready,
    input  abs_pkg::event_t                     ev_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_packet_valid,
    output logic                                m_seq_bit,
    output logic                                m_ack_bit,
    output logic [63:0]                         m_out_word0,
    output logic [63:0]                         m_out_word1,
    output logic [31:0]                         m_out_word2,
    output logic [31:0]                         m_out_checksum,
    output logic                                m_timer_started,
    output logic                                m_timer_stopped,
    output logic                                m_message_dropped
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (TIMER_WIDTH + 1 > abs_pkg::TIMEOUT_WIDTH + 1) ?
                        TIMER_WIDTH + 1 : abs_pkg::TIMEOUT_WIDTH + 1;

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   send_seq_reg, send_seq_next;
    logic                   expect_ack_reg, expect_ack_next;
    logic                   ready_flag_reg, ready_flag_next;
    logic                   timer_running_reg, timer_running_next;
    logic [TIMER_WIDTH-1:0] timer_count_reg, timer_count_next;

    logic res_packet_reg, res_packet_next;
    logic res_seq_reg, res_seq_next;
    logic res_ack_reg, res_ack_next;
    logic res_started_reg, res_started_next;
    logic res_stopped_reg, res_stopped_next;
    logic res_dropped_reg, res_dropped_next;

    logic m_valid_reg, m_valid_next;
    logic m_packet_valid_reg, m_seq_bit_reg, m_ack_bit_reg;
    logic m_timer_started_reg, m_timer_stopped_reg, m_message_dropped_reg;
    logic [63:0] m_out_word0_reg, m_out_word1_reg;
    logic [31:0] m_out_word2_reg, m_out_checksum_reg;

    abs_pkg::payload_t mem [QUEUE_DEPTH];
    abs_pkg::payload_t rd_data_reg;
    logic              wr_en;
    logic              rd_en;
    logic              rd_bypass;
    logic [AW-1:0]     rd_addr;

    logic              has_result;
    logic              out_free;
    logic              out_load;
    logic [LW-1:0]     limit;
    logic [LW-1:0]     cap;
    logic [LW-1:0]     tick_next;
    abs_pkg::payload_t res_payload;
    logic [31:0]       res_checksum;

    assign ev_ready = (state_reg == ST_EXEC);
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_SEND) && out_free;

    always_comb begin
        cap       = LW'(1) << TIMER_WIDTH;
        limit     = (timeout_ticks == '0) ? LW'(1) : LW'(timeout_ticks);
        if (limit > cap) begin
            limit = cap;
        end
        tick_next = LW'(timer_count_reg) + LW'(1);
    end

    always_comb begin
        state_next         = state_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        count_next         = count_reg;
        send_seq_next      = send_seq_reg;
        expect_ack_next    = expect_ack_reg;
        ready_flag_next    = ready_flag_reg;
        timer_running_next = timer_running_reg;
        timer_count_next   = timer_count_reg;
        res_packet_next    = res_packet_reg;
        res_seq_next       = res_seq_reg;
        res_ack_next       = res_ack_reg;
        res_started_next   = res_started_reg;
        res_stopped_next   = res_stopped_reg;
        res_dropped_next   = res_dropped_reg;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        rd_bypass          = 1'b0;
        rd_addr            = head_reg;
        has_result         = 1'b0;

        case (state_reg)
            ST_EXEC: begin
                if (ev_valid) begin
                    res_packet_next  = 1'b0;
                    res_seq_next     = 1'b0;
                    res_ack_next     = 1'b0;
                    res_started_next = 1'b0;
                    res_stopped_next = 1'b0;
                    res_dropped_next = 1'b0;
                    case (ev_data.kind)
                        abs_pkg::EV_NEW: begin
                            if (count_reg >= CW'(QUEUE_DEPTH)) begin
                                res_dropped_next = 1'b1;
                                has_result       = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                tail_next  = next_idx(tail_reg);
                                count_next = count_reg + CW'(1);
                                if (ready_flag_reg) begin
                                    // queue was empty: send the word just written
                                    rd_en              = 1'b1;
                                    rd_bypass          = 1'b1;
                                    res_packet_next    = 1'b1;
                                    res_seq_next       = send_seq_reg;
                                    res_ack_next       = expect_ack_reg;
                                    res_started_next   = 1'b1;
                                    ready_flag_next    = 1'b0;
                                    timer_running_next = 1'b1;
                                    timer_count_next   = '0;
                                    has_result         = 1'b1;
                                end
                            end
                        end
                        abs_pkg::EV_REPLY: begin
                            if (!ready_flag_reg && count_reg != '0 &&
                                ev_data.ack_bit == expect_ack_reg) begin
                                timer_running_next = 1'b0;
                                timer_count_next   = '0;
                                res_stopped_next   = 1'b1;
                                head_next          = next_idx(head_reg);
                                count_next         = count_reg - CW'(1);
                                ready_flag_next    = 1'b1;
                                send_seq_next      = ~send_seq_reg;
                                expect_ack_next    = ~expect_ack_reg;
                                has_result         = 1'b1;
                                if (count_reg != CW'(1)) begin
                                    rd_en              = 1'b1;
                                    rd_addr            = next_idx(head_reg);
                                    res_packet_next    = 1'b1;
                                    res_seq_next       = ~send_seq_reg;
                                    res_ack_next       = ~expect_ack_reg;
                                    res_started_next   = 1'b1;
                                    ready_flag_next    = 1'b0;
                                    timer_running_next = 1'b1;
                                end
                            end
                        end
                        abs_pkg::EV_TICK: begin
                            if (timer_running_reg) begin
                                if (tick_next < limit) begin
                                    timer_count_next = tick_next[TIMER_WIDTH-1:0];
                                end else if (count_reg == '0) begin
                                    timer_running_next = 1'b0;
                                    timer_count_next   = '0;
                                end else begin
                                    rd_en              = 1'b1;
                                    rd_addr            = head_reg;
                                    res_packet_next    = 1'b1;
                                    res_seq_next       = send_seq_reg;
                                    res_ack_next       = expect_ack_reg;
                                    res_started_next   = 1'b1;
                                    ready_flag_next    = 1'b0;
                                    timer_running_next = 1'b1;
                                    timer_count_next   = '0;
                                    has_result         = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (has_result) begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    state_next = ST_EXEC;
                end
            end
            default: begin
                state_next = ST_EXEC;
            end
        endcase
    end

    assign res_payload  = res_packet_reg ? rd_data_reg : '0;
    assign res_checksum = res_packet_reg ?
                          abs_pkg::checksum({31'd0, res_seq_reg}, {31'd0, res_ack_reg},
                                            rd_data_reg) : 32'd0;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_EXEC;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            send_seq_reg      <= 1'b0;
            expect_ack_reg    <= 1'b0;
            ready_flag_reg    <= 1'b1;
            timer_running_reg <= 1'b0;
            timer_count_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            count_reg         <= count_next;
            send_seq_reg      <= send_seq_next;
            expect_ack_reg    <= expect_ack_next;
            ready_flag_reg    <= ready_flag_next;
            timer_running_reg <= timer_running_next;
            timer_count_reg   <= timer_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_packet_reg  <= res_packet_next;
        res_seq_reg     <= res_seq_next;
        res_ack_reg     <= res_ack_next;
        res_started_reg <= res_started_next;
        res_stopped_reg <= res_stopped_next;
        res_dropped_reg <= res_dropped_next;
        if (out_load) begin
            m_packet_valid_reg    <= res_packet_reg;
            m_seq_bit_reg         <= res_packet_reg && res_seq_reg;
            m_ack_bit_reg         <= res_packet_reg && res_ack_reg;
            m_out_word0_reg       <= res_payload[63:0];
            m_out_word1_reg       <= res_payload[127:64];
            m_out_word2_reg       <= res_payload[159:128];
            m_out_checksum_reg    <= res_checksum;
            m_timer_started_reg   <= res_started_reg;
            m_timer_stopped_reg   <= res_stopped_reg;
            m_message_dropped_reg <= res_dropped_reg;
        end
    end

    // message memory, registered read with write-through for the empty case
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= ev_data.payload;
        end
        if (rd_en) begin
            rd_data_reg <= rd_bypass ? ev_data.payload : mem[rd_addr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_packet_valid    = m_packet_valid_reg;
    assign m_seq_bit         = m_seq_bit_reg;
    assign m_ack_bit         = m_ack_bit_reg;
    assign m_out_word0       = m_out_word0_reg;
    assign m_out_word1       = m_out_word1_reg;
    assign m_out_word2       = m_out_word2_reg;
    assign m_out_checksum    = m_out_checksum_reg;
    assign m_timer_started   = m_timer_started_reg;
    assign m_timer_stopped   = m_timer_stopped_reg;
    assign m_message_dropped = m_message_dropped_reg;

endmodule

@@ rtl/core/alternating_bit_sender_top.sv @@
// alternating_bit_sender_top: stop-and-wait sender top level with the
// timeout register. Depends on abs_pkg, abs_front, abs_fifo and abs_back.
//
// Usage:
//   s_* channel: one word per event - new message, reply packet or tick.
//     Replies with a bad checksum or an ack field other than 0/1, and
//     command three, are consumed without effect.
//   m_* channel: one result word per event that sends a packet or raises
//     timer_stopped / message_dropped.
//   cfg_* channel: writes timeout_ticks; always ready, write only when idle.
// Throughput: one word per cycle for events without a result while the back
//   end is idle; for a result word the back end executes and reads the
//   message memory, then forms the checksum into the result word, and takes
//   no new event until that word is loaded.
// Reset: header bits cleared, sender ready, queue empty, timer stopped,
//   timeout_ticks = 20. Message memory contents are left as they are.
// Receiver stall: the result word holds, the back end waits, the two-word
//   event queue fills and then s_ready drops.
module alternating_bit_sender_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_timeout_ticks,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [63:0]          s_payload_word0,
    input  logic [63:0]          s_payload_word1,
    input  logic [31:0]          s_payload_word2,
    input  logic signed [31:0]   s_reply_seq,
    input  logic signed [31:0]   s_reply_ack,
    input  logic [31:0]          s_reply_checksum,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_packet_valid,
    output logic                 m_seq_bit,
    output logic                 m_ack_bit,
    output logic [63:0]          m_out_word0,
    output logic [63:0]          m_out_word1,
    output logic [31:0]          m_out_word2,
    output logic [31:0]          m_out_checksum,
    output logic                 m_timer_started,
    output logic                 m_timer_stopped,
    output logic                 m_message_dropped
);

    logic [abs_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks_reg;

    logic            push_valid;
    logic            push_ready;
    abs_pkg::event_t push_data;
    logic            ev_valid;
    logic            ev_ready;
    abs_pkg::event_t ev_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= abs_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_ticks_reg <= cfg_timeout_ticks;
        end
    end

    abs_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_payload_word0  (s_payload_word0),
        .s_payload_word1  (s_payload_word1),
        .s_payload_word2  (s_payload_word2),
        .s_reply_seq      (s_reply_seq),
        .s_reply_ack      (s_reply_ack),
        .s_reply_checksum (s_reply_checksum),
        .ev_in_ready      (push_ready),
        .ev_push          (push_valid),
        .ev_data          (push_data)
    );

    abs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (ev_valid),
        .out_ready (ev_ready),
        .out_data  (ev_data)
    );

    abs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .timeout_ticks     (timeout_ticks_reg),
        .ev_valid          (ev_valid),
        .ev_ready          (ev_ready),
        .ev_data           (ev_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_packet_valid    (m_packet_valid),
        .m_seq_bit         (m_seq_bit),
        .m_ack_bit         (m_ack_bit),
        .m_out_word0       (m_out_word0),
        .m_out_word1       (m_out_word1),
        .m_out_word2       (m_out_word2),
        .m_out_checksum    (m_out_checksum),
        .m_timer_started   (m_timer_started),
        .m_timer_stopped   (m_timer_stopped),
        .m_message_dropped (m_message_dropped)
    );

endmodule

@@ bench/abs_sender_checker.sv @@
// abs_sender_checker: watches the s_, m_ and cfg_ channels of the alternating-bit
// sender, predicts every result word and compares it with what the block sends.
// Depends on abs_pkg for the command codes and the timeout reset value.
module abs_sender_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_timeout_ticks,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_payload_word0,
    input  logic [63:0] s_payload_word1,
    input  logic [31:0] s_payload_word2,
    input  logic [31:0] s_reply_seq,
    input  logic [31:0] s_reply_ack,
    input  logic [31:0] s_reply_checksum,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_packet_valid,
    input  logic        m_seq_bit,
    input  logic        m_ack_bit,
    input  logic [63:0] m_out_word0,
    input  logic [63:0] m_out_word1,
    input  logic [31:0] m_out_word2,
    input  logic [31:0] m_out_checksum,
    input  logic        m_timer_started,
    input  logic        m_timer_stopped,
    input  logic        m_message_dropped,
    output int          errors,
    output int          pending,
    output logic        ack_hint
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        packet_valid;
        logic        seq_bit;
        logic        ack_bit;
        logic [63:0] word0;
        logic [63:0] word1;
        logic [31:0] word2;
        logic [31:0] sum;
        logic        timer_started;
        logic        timer_stopped;
        logic        message_dropped;
    } sender_word_t;

    logic [63:0]  msg_lo  [QUEUE_DEPTH];
    logic [63:0]  msg_mid [QUEUE_DEPTH];
    logic [31:0]  msg_hi  [QUEUE_DEPTH];
    int           rd_ptr;
    int           wr_ptr;
    int           fill;
    int           tmr_ticks;
    logic         tx_seq;
    logic         rx_ack;
    logic         idle_flag;
    logic         tmr_on;
    logic [15:0]  tmo_ticks;
    sender_word_t words_due[$];

    // inverted wrapping sum of both header fields and the sign-extended bytes
    function automatic logic [31:0] packet_sum(input logic [31:0] seq, input logic [31:0] ack,
                                               input logic [63:0] w0, input logic [63:0] w1,
                                               input logic [31:0] w2);
        logic [159:0] bytes;
        logic [31:0]  acc;
        bytes = {w2, w1, w0};
        acc   = seq + ack;
        for (int i = 0; i < 20; i++) begin
            acc = acc + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
        end
        return ~acc;
    endfunction

    function automatic string describe(input sender_word_t w);
        return $sformatf(
            "pkt=%0b seq=%0b ack=%0b w0=%h w1=%h w2=%h sum=%h tmr=%0b/%0b drop=%0b",
            w.packet_valid, w.seq_bit, w.ack_bit, w.word0, w.word1, w.word2, w.sum,
            w.timer_started, w.timer_stopped, w.message_dropped);
    endfunction

    task automatic emit_head(inout sender_word_t r);
        r.packet_valid  = 1'b1;
        r.seq_bit       = tx_seq;
        r.ack_bit       = rx_ack;
        r.word0         = msg_lo[rd_ptr];
        r.word1         = msg_mid[rd_ptr];
        r.word2         = msg_hi[rd_ptr];
        r.sum           = packet_sum({31'b0, tx_seq}, {31'b0, rx_ack}, msg_lo[rd_ptr],
                                     msg_mid[rd_ptr], msg_hi[rd_ptr]);
        r.timer_started = 1'b1;
        idle_flag       = 1'b0;
        tmr_on          = 1'b1;
        tmr_ticks       = 0;
    endtask

    task automatic advance_sender(input logic [1:0] cmd, input logic [63:0] w0,
                                  input logic [63:0] w1, input logic [31:0] w2,
                                  input logic [31:0] rseq, input logic [31:0] rack,
                                  input logic [31:0] rsum);
        sender_word_t r;
        int           lim;
        r = '0;
        case (cmd)
            abs_pkg::CMD_NEW: begin
                if (fill >= QUEUE_DEPTH) begin
                    r.message_dropped = 1'b1;
                    words_due.push_back(r);
                end else begin
                    msg_lo[wr_ptr]  = w0;
                    msg_mid[wr_ptr] = w1;
                    msg_hi[wr_ptr]  = w2;
                    wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
                    fill++;
                    if (idle_flag) begin
                        emit_head(r);
                        words_due.push_back(r);
                    end
                end
            end
            abs_pkg::CMD_REPLY: begin
                if (!idle_flag && fill != 0 && rack == {31'b0, rx_ack}
                    && rsum == packet_sum(rseq, rack, w0, w1, w2)) begin
                    tmr_on          = 1'b0;
                    tmr_ticks       = 0;
                    r.timer_stopped = 1'b1;
                    rd_ptr          = (rd_ptr + 1) % QUEUE_DEPTH;
                    fill--;
                    idle_flag       = 1'b1;
                    tx_seq          = ~tx_seq;
                    rx_ack          = ~rx_ack;
                    if (fill != 0) emit_head(r);
                    words_due.push_back(r);
                end
            end
            abs_pkg::CMD_TICK: begin
                if (tmr_on) begin
                    lim = (tmo_ticks == 16'd0) ? 1 : int'(tmo_ticks);
                    if (tmr_ticks + 1 < lim) begin
                        tmr_ticks++;
                    end else if (fill == 0) begin
                        tmr_on    = 1'b0;
                        tmr_ticks = 0;
                    end else begin
                        emit_head(r);
                        words_due.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        sender_word_t got;
        sender_word_t want;
        if (!aresetn) begin
            tx_seq    = 1'b0;
            rx_ack    = 1'b0;
            idle_flag = 1'b1;
            rd_ptr    = 0;
            wr_ptr    = 0;
            fill      = 0;
            tmr_on    = 1'b0;
            tmr_ticks = 0;
            tmo_ticks = abs_pkg::TIMEOUT_RESET;
            words_due.delete();
            errors   <= 0;
        end else begin
            if (cfg_valid && cfg_ready) tmo_ticks = cfg_timeout_ticks;
            if (s_valid && s_ready) begin
                advance_sender(s_command, s_payload_word0, s_payload_word1, s_payload_word2,
                               s_reply_seq, s_reply_ack, s_reply_checksum);
            end
            if (m_valid && m_ready) begin
                got = {m_packet_valid, m_seq_bit, m_ack_bit, m_out_word0, m_out_word1,
                       m_out_word2, m_out_checksum, m_timer_started, m_timer_stopped,
                       m_message_dropped};
                if (words_due.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result word: expected none, actual %s",
                             $time, describe(got));
                end else begin
                    want = words_due.pop_front();
                    if (got !== want) begin
                        errors <= errors + 1;
                        $display("%0t: result word mismatch: expected %s, actual %s",
                                 $time, describe(want), describe(got));
                    end
                end
            end
        end
        pending  <= words_due.size();
        ack_hint <= rx_ack;
    end

endmodule

@@ bench/alternating_bit_sender_top_tb.sv @@
// alternating_bit_sender_top_tb: drives events and timeout writes into the
// alternating-bit sender with random gaps and stalls; abs_sender_checker judges.
// Depends on abs_pkg, alternating_bit_sender_top and abs_sender_checker.
module alternating_bit_sender_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         PHASES      = 7;
    localparam int         PHASE_WORDS = 165;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_timeout_ticks;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [63:0] s_payload_word0;
    logic [63:0] s_payload_word1;
    logic [31:0] s_payload_word2;
    logic [31:0] s_reply_seq;
    logic [31:0] s_reply_ack;
    logic [31:0] s_reply_checksum;
    logic        m_valid;
    logic        m_ready;
    logic        m_packet_valid;
    logic        m_seq_bit;
    logic        m_ack_bit;
    logic [63:0] m_out_word0;
    logic [63:0] m_out_word1;
    logic [31:0] m_out_word2;
    logic [31:0] m_out_checksum;
    logic        m_timer_started;
    logic        m_timer_stopped;
    logic        m_message_dropped;
    int          errors;
    int          pending;
    logic        ack_hint;

    int          quiet     = 0;
    int          calm_left = 0;

    logic [15:0] phase_tmo   [PHASES] = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd9, 16'd20};
    int          phase_new   [PHASES] = '{35, 30, 65, 40, 30, 25, 35};
    int          phase_reply [PHASES] = '{35, 35, 15, 40, 30, 35, 30};
    int          phase_tick  [PHASES] = '{25, 30, 15, 15, 35, 35, 30};

    alternating_bit_sender_top dut (.*);
    abs_sender_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 550) return 0;
        if (r < 870) return $urandom_range(1, 3);
        if (r < 975) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [159:0] rand_payload();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {20{8'h80}};
            3:       return {20{8'h7F}};
            default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    task automatic put_word(input logic [1:0] cmd, input logic [159:0] p,
                            input logic [31:0] seq, input logic [31:0] ack,
                            input logic [31:0] csum);
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_payload_word0  <= p[63:0];
        s_payload_word1  <= p[127:64];
        s_payload_word2  <= p[159:128];
        s_reply_seq      <= seq;
        s_reply_ack      <= ack;
        s_reply_checksum <= csum;
        do @(posedge aclk); while (!s_ready);
        if (pick_gap() > 0) begin
            s_valid <= 1'b0;
            repeat (pick_gap() + 1) @(posedge aclk);
        end
    endtask

    task automatic put_plain(input logic [1:0] cmd, input logic [159:0] p);
        put_word(cmd, p, $urandom, $urandom, $urandom);
    endtask

    task automatic put_reply(input logic [159:0] p, input logic [31:0] seq,
                             input logic [31:0] ack, input bit spoil);
        logic [31:0] csum;
        csum = abs_pkg::checksum(seq, ack, p);
        if (spoil) csum = csum ^ (32'd1 << $urandom_range(0, 31));
        put_word(abs_pkg::CMD_REPLY, p, seq, ack, csum);
    endtask

    task automatic random_item(input int new_w, input int reply_w, input int tick_w);
        int          r;
        logic [31:0] ack;
        logic [159:0] p;
        r   = $urandom_range(0, 99);
        p   = rand_payload();
        ack = {31'b0, ack_hint};
        if (r < new_w) begin
            put_plain(abs_pkg::CMD_NEW, p);
        end else if (r < new_w + reply_w) begin
            case ($urandom_range(0, 9))
                0:       put_reply(p, $urandom, ack, 1'b1);
                1:       put_reply(p, $urandom, $urandom, 1'b0);
                2:       put_reply(p, $urandom, ack ^ 32'd1, 1'b0);
                default: put_reply(p, $urandom, ack, 1'b0);
            endcase
        end else if (r < new_w + reply_w + tick_w) begin
            put_plain(abs_pkg::CMD_TICK, p);
        end else begin
            put_plain(CMD_SPARE, p);
        end
    endtask

    // drain all outstanding words, then give the back end time to go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        cfg_valid         <= 1'b1;
        cfg_timeout_ticks <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int mix_len;
        m_ready <= 1'b1;
        forever begin
            mix_len = ($urandom_range(0, 9) == 0) ? 150 : 12;
            repeat ($urandom_range(1, mix_len)) @(posedge aclk);
            m_ready <= 1'b0;
            case ($urandom_range(0, 19))
                0:       repeat ($urandom_range(20, 60)) @(posedge aclk);
                1, 2, 3: repeat ($urandom_range(4, 12)) @(posedge aclk);
                default: repeat ($urandom_range(1, 3)) @(posedge aclk);
            endcase
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        aresetn           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_timeout_ticks <= abs_pkg::TIMEOUT_RESET;
        s_valid           <= 1'b0;
        s_command         <= abs_pkg::CMD_NEW;
        s_payload_word0   <= '0;
        s_payload_word1   <= '0;
        s_payload_word2   <= '0;
        s_reply_seq       <= '0;
        s_reply_ack       <= '0;
        s_reply_checksum  <= '0;
        phase_tmo[5]       = 16'($urandom_range(4, 40));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short timeout so retransmission shows up within a few ticks
        set_timeout(16'd2);
        put_plain(abs_pkg::CMD_NEW, '0);
        put_reply(rand_payload(), $urandom, 32'd0, 1'b1);
        put_reply(rand_payload(), $urandom, 32'd1, 1'b0);
        put_reply(rand_payload(), 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        put_plain(abs_pkg::CMD_NEW, '1);
        put_plain(abs_pkg::CMD_NEW, {20{8'h80}});
        put_plain(abs_pkg::CMD_TICK, rand_payload());
        put_plain(abs_pkg::CMD_TICK, rand_payload());
        put_reply({20{8'h7F}}, 32'hFFFF_FFFF, 32'd0, 1'b0);
        put_reply(rand_payload(), 32'd0, 32'd1, 1'b0);
        put_reply(rand_payload(), $urandom, 32'd0, 1'b0);
        put_reply(rand_payload(), $urandom, 32'd1, 1'b0);
        put_plain(abs_pkg::CMD_TICK, rand_payload());
        put_plain(CMD_SPARE, rand_payload());
        put_plain(abs_pkg::CMD_NEW, rand_payload());
        put_plain(abs_pkg::CMD_TICK, rand_payload());
        put_plain(abs_pkg::CMD_TICK, rand_payload());

        for (int i = 0; i < PHASES; i++) begin
            settle();
            set_timeout(phase_tmo[i]);
            repeat (PHASE_WORDS) random_item(phase_new[i], phase_reply[i], phase_tick[i]);
        end
        settle();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
